[rtl/gnpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnpr_pkg
// Shared widths, codes and types of the graph node partition reindexer.
// ----------------------------------------------------------------------------
package gnpr_pkg;

  localparam int TABLE_AW    = 16;
  localparam int TABLE_DEPTH = 1 << TABLE_AW;
  localparam int NODE_W      = 17;
  localparam int PART_W      = 9;
  localparam int SLOT_W      = 8;
  localparam int ROW_W       = 16;
  localparam int IDX_W       = 16;
  localparam int ID_W        = 16;
  localparam int CFG_IW      = 1;
  localparam int CFG_DW      = 17;
  localparam int DIV_CW      = $clog2(NODE_W);
  localparam int IN_DW       = 32;
  localparam int OUT_DW      = 40;

  localparam logic [NODE_W-1:0] MAX_NODES = NODE_W'(65536);
  localparam logic [PART_W-1:0] MAX_PARTS = PART_W'(256);

  localparam logic [CFG_IW-1:0] CFG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_PART_COUNT = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SRC,
    S_TGT
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
  } entry_t;

  typedef struct packed {
    logic              done;
    logic [NODE_W-1:0] quo;
    logic [PART_W-1:0] rem;
  } div_res_t;

endpackage

[rtl/graph_node_partition_reindexer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_node_partition_reindexer_unit
// Maps the two node ids of each edge to partition-contiguous indices through
// a 64K-entry lookup memory.
// ----------------------------------------------------------------------------
// An edge passes through S_SRC and then S_TGT when the result side keeps
// up: the source lookup resolves in S_SRC while the target is read, and the
// target resolves in S_TGT, when the next edge may already be transferred.
// The split is set by the lookup memory, which does one read and one write
// per cycle. After reset the memory is cleared one entry per cycle, so no
// input transfer is taken until every entry is cleared. Each configuration
// write starts a division that derives the part size; input is held off
// until it finishes.
module graph_node_partition_reindexer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // source_node [15:0], target_node [31:16]
  input  logic [gnpr_pkg::IN_DW-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // source_index [15:0], target_index [31:16], source_fresh [32],
  // target_fresh [33], source_changed [34], table_full [35], zeros above
  output logic [gnpr_pkg::OUT_DW-1:0] out_tdata,
  input  logic                        cfg_we,
  input  logic [gnpr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [gnpr_pkg::CFG_DW-1:0] cfg_wdata
);
  import gnpr_pkg::*;

  state_t state_r, state_nxt;

  entry_t idx_mem [TABLE_DEPTH];
  entry_t mem_rdata_r;
  entry_t fwd_entry_r;
  logic   fwd_hit_r;

  logic                wr_en, rd_en;
  logic [TABLE_AW-1:0] wr_addr, rd_addr;
  entry_t              wr_data;

  logic [TABLE_AW-1:0] clr_r;
  logic [NODE_W-1:0]   node_count_r;
  logic [PART_W-1:0]   part_count_r;
  logic [NODE_W-1:0]   base_r;
  logic [PART_W-1:0]   rem_r;
  logic [NODE_W-1:0]   eff_nodes;
  logic [PART_W-1:0]   eff_parts;
  logic                div_start_r;
  logic                div_busy;
  div_res_t            div_res;

  logic [NODE_W-1:0] assigned_r;
  logic [SLOT_W-1:0] slot_r;
  logic [ROW_W-1:0]  row_r;

  logic [ID_W-1:0]  src_r, tgt_r;
  logic [IDX_W-1:0] s_idx_r;
  logic             s_fresh_r, s_full_r, s_changed_r;
  logic [IDX_W-1:0] prev_idx_r;
  logic             prev_valid_r;

  logic                out_tvalid_r;
  logic [OUT_DW-1:0]   out_tdata_r;

  logic              accept, out_free, resolve_en, div_hold;
  logic              load_src, load_out;
  entry_t            rd_entry;
  logic [SLOT_W-1:0] lo;
  logic [SLOT_W+IDX_W-1:0] prod;
  logic [IDX_W-1:0]  new_idx;
  logic              can_assign, miss, do_assign, res_full;
  logic [IDX_W-1:0]  res_idx;

  // Configuration and derived part size.
  assign eff_nodes = (node_count_r > MAX_NODES) ? MAX_NODES : node_count_r;
  always_comb begin
    eff_parts = part_count_r;
    if (part_count_r == '0) eff_parts = PART_W'(1);
    else if (part_count_r > MAX_PARTS) eff_parts = MAX_PARTS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= MAX_NODES;
      part_count_r <= PART_W'(1);
      div_start_r  <= 1'b0;
      base_r       <= MAX_NODES;
      rem_r        <= '0;
    end else begin
      div_start_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NODE_COUNT: node_count_r <= cfg_wdata;
          CFG_PART_COUNT: part_count_r <= cfg_wdata[PART_W-1:0];
        endcase
      end
      if (div_res.done) begin
        base_r <= div_res.quo;
        rem_r  <= div_res.rem;
      end
    end
  end

  gnpr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (eff_nodes),
    .divisor  (eff_parts),
    .busy     (div_busy),
    .res      (div_res)
  );

  assign div_hold = div_start_r | div_busy | div_res.done;

  // Lookup resolution shared by the source and target cycles.
  assign rd_entry   = fwd_hit_r ? fwd_entry_r : mem_rdata_r;
  assign lo         = ({1'b0, slot_r} < rem_r) ? slot_r : rem_r[SLOT_W-1:0];
  assign prod       = slot_r * base_r[IDX_W-1:0];
  assign new_idx    = prod[IDX_W-1:0] + IDX_W'(lo) + row_r;
  assign can_assign = assigned_r < eff_nodes;
  assign miss       = !rd_entry.valid;
  assign do_assign  = resolve_en && miss && can_assign;
  assign res_full   = miss && !can_assign;
  assign res_idx    = rd_entry.valid ? rd_entry.idx : (can_assign ? new_idx : '0);

  assign out_free = !out_tvalid_r;
  assign accept   = in_tvalid && in_tready;

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    resolve_en = 1'b0;
    load_src   = 1'b0;
    load_out   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = src_r;
    wr_data    = '{valid: 1'b1, idx: res_idx};
    rd_en      = 1'b0;
    rd_addr    = in_tdata[ID_W-1:0];
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = !div_hold;
        rd_en     = accept;
        if (accept) state_nxt = S_SRC;
      end
      S_SRC: begin
        resolve_en = 1'b1;
        load_src   = 1'b1;
        wr_en      = do_assign;
        rd_en      = 1'b1;
        rd_addr    = tgt_r;
        state_nxt  = S_TGT;
      end
      S_TGT: begin
        in_tready = out_free && !div_hold;
        if (out_free) begin
          resolve_en = 1'b1;
          load_out   = 1'b1;
          wr_en      = do_assign;
          wr_addr    = tgt_r;
          rd_en      = accept;
          state_nxt  = accept ? S_SRC : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  // Lookup memory with forwarding of a write issued alongside the read.
  always_ff @(posedge clk) begin
    if (wr_en) idx_mem[wr_addr] <= wr_data;
    if (rd_en) mem_rdata_r <= idx_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_hit_r   <= wr_en && (wr_addr == rd_addr);
      fwd_entry_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r        <= '0;
      assigned_r   <= '0;
      slot_r       <= '0;
      row_r        <= '0;
      prev_valid_r <= 1'b0;
    end else begin
      if (state_r == S_CLEAR) clr_r <= clr_r + TABLE_AW'(1);
      if (do_assign) begin
        assigned_r <= assigned_r + NODE_W'(1);
        if ({1'b0, slot_r} + PART_W'(1) >= eff_parts) begin
          slot_r <= '0;
          row_r  <= row_r + ROW_W'(1);
        end else begin
          slot_r <= slot_r + SLOT_W'(1);
        end
      end
      if (load_src) prev_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src_r <= in_tdata[ID_W-1:0];
      tgt_r <= in_tdata[2*ID_W-1:ID_W];
    end
    if (load_src) begin
      s_idx_r     <= res_idx;
      s_fresh_r   <= do_assign;
      s_full_r    <= res_full;
      s_changed_r <= !prev_valid_r || (prev_idx_r != res_idx);
      prev_idx_r  <= res_idx;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= {4'b0000, s_full_r | res_full, s_changed_r, do_assign,
                      s_fresh_r, res_idx, s_idx_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[rtl/gnpr_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnpr_div
// Restoring divider that derives the base part size and the remainder, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module gnpr_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [gnpr_pkg::NODE_W-1:0] dividend,
  input  logic [gnpr_pkg::PART_W-1:0] divisor,
  output logic                      busy,
  output gnpr_pkg::div_res_t        res
);
  import gnpr_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [NODE_W-1:0] quo_r;
  logic [PART_W-1:0] rem_r;
  logic [PART_W-1:0] dsr_r;
  logic [PART_W:0]   trial;
  logic              ge;

  assign trial = {rem_r, quo_r[NODE_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CW'(1);
        if (cnt_r == DIV_CW'(NODE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[NODE_W-2:0], ge};
      rem_r <= ge ? PART_W'(trial - {1'b0, dsr_r}) : trial[PART_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

endmodule

[rtl/gnpr_sva.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnpr_sva
// Port-level checks of the graph node partition reindexer, bound to the top.
// ----------------------------------------------------------------------------
module gnpr_sva (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [gnpr_pkg::OUT_DW-1:0] out_tdata,
  input logic                        cfg_we
);
  import gnpr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input transfers on consecutive cycles");

  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_tready)
    else $error("input taken while part size is derived");

  a_full_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[35] |-> !(out_tdata[32] && out_tdata[33]))
    else $error("table full with both ends fresh");

endmodule

bind graph_node_partition_reindexer_unit gnpr_sva u_gnpr_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_we     (cfg_we)
);
